FILE: rtl/dscl_pkg.sv
// Package with the calibration curve tables and shared types of the linearizer.
package dscl_pkg;

    localparam int VoltW  = 18;
    localparam int TempW  = 19;
    localparam int TableLen = 120;
    localparam int IdxW   = 7;
    localparam int DropW  = 17;
    localparam int SpanW  = 12;
    localparam int ProdW  = DropW + VoltW;

    // Voltage breakpoint of the curve, in units of 10 uV.
    function automatic logic [VoltW-1:0] volt_bp(input logic [IdxW-1:0] i);
        logic [VoltW-1:0] v;
        case (i)
            7'd0: v = 18'd9062;     7'd1: v = 18'd10191;   7'd2: v = 18'd12547;
            7'd3: v = 18'd14985;    7'd4: v = 18'd17464;   7'd5: v = 18'd19961;
            7'd6: v = 18'd22463;    7'd7: v = 18'd24963;   7'd8: v = 18'd27456;
            7'd9: v = 18'd29941;    7'd10: v = 18'd32416;  7'd11: v = 18'd34881;
            7'd12: v = 18'd37337;   7'd13: v = 18'd39783;  7'd14: v = 18'd42221;
            7'd15: v = 18'd44647;   7'd16: v = 18'd47069;  7'd17: v = 18'd49484;
            7'd18: v = 18'd51892;   7'd19: v = 18'd54294;  7'd20: v = 18'd56690;
            7'd21: v = 18'd59080;   7'd22: v = 18'd61465;  7'd23: v = 18'd63841;
            7'd24: v = 18'd66208;   7'd25: v = 18'd68564;  7'd26: v = 18'd70908;
            7'd27: v = 18'd73238;   7'd28: v = 18'd75554;  7'd29: v = 18'd77855;
            7'd30: v = 18'd80138;   7'd31: v = 18'd82404;  7'd32: v = 18'd84650;
            7'd33: v = 18'd86873;   7'd34: v = 18'd89072;  7'd35: v = 18'd91243;
            7'd36: v = 18'd93383;   7'd37: v = 18'd95487;  7'd38: v = 18'd97550;
            7'd39: v = 18'd98564;   7'd40: v = 18'd99565;  7'd41: v = 18'd100552;
            7'd42: v = 18'd101525;  7'd43: v = 18'd102482; 7'd44: v = 18'd103425;
            7'd45: v = 18'd104353;  7'd46: v = 18'd105267; 7'd47: v = 18'd105629;
            7'd48: v = 18'd105988;  7'd49: v = 18'd106346; 7'd50: v = 18'd106700;
            7'd51: v = 18'd107053;  7'd52: v = 18'd107402; 7'd53: v = 18'd107748;
            7'd54: v = 18'd108093;  7'd55: v = 18'd108436; 7'd56: v = 18'd108781;
            7'd57: v = 18'd109131;  7'd58: v = 18'd109490; 7'd59: v = 18'd109864;
            7'd60: v = 18'd110263;  7'd61: v = 18'd110702; 7'd62: v = 18'd110945;
            7'd63: v = 18'd111212;  7'd64: v = 18'd111517; 7'd65: v = 18'd111896;
            7'd66: v = 18'd112463;  7'd67: v = 18'd113598; 7'd68: v = 18'd115558;
            7'd69: v = 18'd117705;  7'd70: v = 18'd119645; 7'd71: v = 18'd121440;
            7'd72: v = 18'd122314;  7'd73: v = 18'd123184; 7'd74: v = 18'd124053;
            7'd75: v = 18'd124928;  7'd76: v = 18'd125810; 7'd77: v = 18'd126702;
            7'd78: v = 18'd127607;  7'd79: v = 18'd128527; 7'd80: v = 18'd129464;
            7'd81: v = 18'd130422;  7'd82: v = 18'd131403; 7'd83: v = 18'd132412;
            7'd84: v = 18'd133453;  7'd85: v = 18'd134530; 7'd86: v = 18'd135647;
            7'd87: v = 18'd136809;  7'd88: v = 18'd138021; 7'd89: v = 18'd139287;
            7'd90: v = 18'd140615;  7'd91: v = 18'd142013; 7'd92: v = 18'd143488;
            7'd93: v = 18'd145048;  7'd94: v = 18'd146700; 7'd95: v = 18'd148443;
            7'd96: v = 18'd150272;  7'd97: v = 18'd152166; 7'd98: v = 18'd154097;
            7'd99: v = 18'd156027;  7'd100: v = 18'd157928; 7'd101: v = 18'd159782;
            7'd102: v = 18'd160506; 7'd103: v = 18'd161220; 7'd104: v = 18'd161920;
            7'd105: v = 18'd162602; 7'd106: v = 18'd163263; 7'd107: v = 18'd163905;
            7'd108: v = 18'd164529; 7'd109: v = 18'd165134; 7'd110: v = 18'd165721;
            7'd111: v = 18'd166292; 7'd112: v = 18'd166845; 7'd113: v = 18'd167376;
            7'd114: v = 18'd167880; 7'd115: v = 18'd168352; 7'd116: v = 18'd168786;
            7'd117: v = 18'd169177; 7'd118: v = 18'd169521; 7'd119: v = 18'd169812;
            default: v = 18'h3FFFF;
        endcase
        return v;
    endfunction

    // Temperature of the curve at a breakpoint, in millikelvin.
    function automatic logic [TempW-1:0] temp_bp(input logic [IdxW-1:0] i);
        logic [TempW-1:0] t;
        case (i)
            7'd0: t = 19'd475000;  7'd1: t = 19'd470000;  7'd2: t = 19'd460000;
            7'd3: t = 19'd450000;  7'd4: t = 19'd440000;  7'd5: t = 19'd430000;
            7'd6: t = 19'd420000;  7'd7: t = 19'd410000;  7'd8: t = 19'd400000;
            7'd9: t = 19'd390000;  7'd10: t = 19'd380000; 7'd11: t = 19'd370000;
            7'd12: t = 19'd360000; 7'd13: t = 19'd350000; 7'd14: t = 19'd340000;
            7'd15: t = 19'd330000; 7'd16: t = 19'd320000; 7'd17: t = 19'd310000;
            7'd18: t = 19'd300000; 7'd19: t = 19'd290000; 7'd20: t = 19'd280000;
            7'd21: t = 19'd270000; 7'd22: t = 19'd260000; 7'd23: t = 19'd250000;
            7'd24: t = 19'd240000; 7'd25: t = 19'd230000; 7'd26: t = 19'd220000;
            7'd27: t = 19'd210000; 7'd28: t = 19'd200000; 7'd29: t = 19'd190000;
            7'd30: t = 19'd180000; 7'd31: t = 19'd170000; 7'd32: t = 19'd160000;
            7'd33: t = 19'd150000; 7'd34: t = 19'd140000; 7'd35: t = 19'd130000;
            7'd36: t = 19'd120000; 7'd37: t = 19'd110000; 7'd38: t = 19'd100000;
            7'd39: t = 19'd95000;  7'd40: t = 19'd90000;  7'd41: t = 19'd85000;
            7'd42: t = 19'd80000;  7'd43: t = 19'd75000;  7'd44: t = 19'd70000;
            7'd45: t = 19'd65000;  7'd46: t = 19'd60000;  7'd47: t = 19'd58000;
            7'd48: t = 19'd56000;  7'd49: t = 19'd54000;  7'd50: t = 19'd52000;
            7'd51: t = 19'd50000;  7'd52: t = 19'd48000;  7'd53: t = 19'd46000;
            7'd54: t = 19'd44000;  7'd55: t = 19'd42000;  7'd56: t = 19'd40000;
            7'd57: t = 19'd38000;  7'd58: t = 19'd36000;  7'd59: t = 19'd34000;
            7'd60: t = 19'd32000;  7'd61: t = 19'd30000;  7'd62: t = 19'd29000;
            7'd63: t = 19'd28000;  7'd64: t = 19'd27000;  7'd65: t = 19'd26000;
            7'd66: t = 19'd25000;  7'd67: t = 19'd24000;  7'd68: t = 19'd23000;
            7'd69: t = 19'd22000;  7'd70: t = 19'd21000;  7'd71: t = 19'd20000;
            7'd72: t = 19'd19500;  7'd73: t = 19'd19000;  7'd74: t = 19'd18500;
            7'd75: t = 19'd18000;  7'd76: t = 19'd17500;  7'd77: t = 19'd17000;
            7'd78: t = 19'd16500;  7'd79: t = 19'd16000;  7'd80: t = 19'd15500;
            7'd81: t = 19'd15000;  7'd82: t = 19'd14500;  7'd83: t = 19'd14000;
            7'd84: t = 19'd13500;  7'd85: t = 19'd13000;  7'd86: t = 19'd12500;
            7'd87: t = 19'd12000;  7'd88: t = 19'd11500;  7'd89: t = 19'd11000;
            7'd90: t = 19'd10500;  7'd91: t = 19'd10000;  7'd92: t = 19'd9500;
            7'd93: t = 19'd9000;   7'd94: t = 19'd8500;   7'd95: t = 19'd8000;
            7'd96: t = 19'd7500;   7'd97: t = 19'd7000;   7'd98: t = 19'd6500;
            7'd99: t = 19'd6000;   7'd100: t = 19'd5500;  7'd101: t = 19'd5000;
            7'd102: t = 19'd4800;  7'd103: t = 19'd4600;  7'd104: t = 19'd4400;
            7'd105: t = 19'd4200;  7'd106: t = 19'd4000;  7'd107: t = 19'd3800;
            7'd108: t = 19'd3600;  7'd109: t = 19'd3400;  7'd110: t = 19'd3200;
            7'd111: t = 19'd3000;  7'd112: t = 19'd2800;  7'd113: t = 19'd2600;
            7'd114: t = 19'd2400;  7'd115: t = 19'd2200;  7'd116: t = 19'd2000;
            7'd117: t = 19'd1800;  7'd118: t = 19'd1600;  7'd119: t = 19'd1400;
            default: t = 19'd1400;
        endcase
        return t;
    endfunction

    // Segment data handed from the search stages to the interpolation stages.
    typedef struct packed {
        logic             clamp;
        logic [TempW-1:0] t_lo;
        logic [DropW-1:0] drop;
        logic [VoltW-1:0] off;
        logic [SpanW-1:0] span;
    } seg_t;

endpackage

FILE: rtl/diode_sensor_curve_linearizer_top.sv
// Stages from input transaction to result: 9 search, 1 multiply,
// 4 divide, 1 subtract; the subtract register drives the output.
// Throughput: one sample per cycle; the whole pipeline advances unless the
// output holds a valid result that is not taken.
// The depth is set by the 7-bit binary search and the 4-step divider.
// Reset clears all valid bits; data registers are not reset.
module diode_sensor_curve_linearizer_top #(
    parameter int CURVE_POINTS = 120
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [17:0] sensor_voltage
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [18:0] temperature_mk
);
    logic           adv;
    logic           sv;
    dscl_pkg::seg_t seg;
    logic           iv;
    logic [dscl_pkg::TempW-1:0] temp;

    // Pipeline advances when the last stage is empty or being drained.
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    dscl_search #(.CURVE_POINTS(CURVE_POINTS)) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s_axis_tvalid),
        .in_volt  (s_axis_tdata[dscl_pkg::VoltW-1:0]),
        .out_valid(sv),
        .out_seg  (seg)
    );

    dscl_interp u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (sv),
        .in_seg   (seg),
        .out_valid(iv),
        .out_temp (temp)
    );

    assign m_axis_tvalid = iv;
    assign m_axis_tdata  = {5'b0, temp};

    // Stalled output holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    // Results stay on the curve range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> temp >= 19'd1400 && temp <= 19'd475000)
        else $error("temperature out of range");
    // Ready follows the output stage.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready mismatch");

endmodule

FILE: rtl/dscl_search.sv
// Pipelined binary search over the breakpoints, one index bit per stage.
module dscl_search #(
    parameter int CURVE_POINTS = 120
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [dscl_pkg::VoltW-1:0]    in_volt,
    output logic                          out_valid,
    output dscl_pkg::seg_t                out_seg
);
    localparam int Used = (CURVE_POINTS < dscl_pkg::TableLen) ? CURVE_POINTS
                                                               : dscl_pkg::TableLen;
    localparam int IW = dscl_pkg::IdxW;
    localparam int St = IW + 1;

    // Stage k holds a count of breakpoints below the input, bits decided MSB first.
    logic                          vld_reg  [St];
    logic [dscl_pkg::VoltW-1:0]    volt_reg [St];
    logic [IW:0]                   cnt_reg  [St];
    logic                          vld_next [St];
    logic [dscl_pkg::VoltW-1:0]    volt_next[St];
    logic [IW:0]                   cnt_next [St];

    // Search stages: try setting one more bit of the count.
    always_comb
    begin
        logic [IW:0]   trial;
        logic [IW-1:0] probe;
        for (int k = 0; k < St; k++)
        begin
            if (k == 0)
            begin
                vld_next[k]  = in_valid;
                volt_next[k] = in_volt;
                cnt_next[k]  = '0;
            end
            else
            begin
                vld_next[k]  = vld_reg[k-1];
                volt_next[k] = volt_reg[k-1];
                trial = cnt_reg[k-1] | ((IW+1)'(1) << (IW - k));
                probe = IW'(trial - (IW+1)'(1));
                if (trial <= (IW+1)'(Used) && volt_reg[k-1] > dscl_pkg::volt_bp(probe))
                    cnt_next[k] = trial;
                else
                    cnt_next[k] = cnt_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < St; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            for (int k = 0; k < St; k++)
                vld_reg[k] <= vld_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < St; k++)
            begin
                volt_reg[k] <= volt_next[k];
                cnt_reg[k]  <= cnt_next[k];
            end
        end
    end

    // Segment fetch: read both ends of the found segment from the tables.
    logic [IW:0]                 cnt;
    logic [IW-1:0]               ihi, ilo;
    logic [dscl_pkg::VoltW-1:0]  vlo, vhi;
    logic [dscl_pkg::TempW-1:0]  tlo, thi;
    dscl_pkg::seg_t              seg_next, seg_reg;
    logic                        ov_reg;

    assign cnt = cnt_reg[St-1];
    assign ihi = IW'(cnt);
    assign ilo = IW'(cnt - (IW+1)'(1));
    assign vlo = dscl_pkg::volt_bp(ilo);
    assign vhi = dscl_pkg::volt_bp(ihi);
    assign tlo = dscl_pkg::temp_bp(ilo);
    assign thi = dscl_pkg::temp_bp(ihi);

    always_comb
    begin
        seg_next = '0;
        if (cnt == '0)
        begin
            seg_next.clamp = 1'b1;
            seg_next.t_lo  = dscl_pkg::temp_bp('0);
        end
        else if (cnt >= (IW+1)'(Used))
        begin
            seg_next.clamp = 1'b1;
            seg_next.t_lo  = dscl_pkg::temp_bp(IW'(Used - 1));
        end
        else
        begin
            seg_next.clamp = 1'b0;
            seg_next.t_lo  = tlo;
            seg_next.drop  = dscl_pkg::DropW'(tlo - thi);
            seg_next.off   = volt_reg[St-1] - vlo;
            seg_next.span  = dscl_pkg::SpanW'(vhi - vlo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= vld_reg[St-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            seg_reg <= seg_next;
    end

    assign out_valid = ov_reg;
    assign out_seg   = seg_reg;

endmodule

FILE: rtl/dscl_interp.sv
// Interpolation stages: registered multiply, then a pipelined restoring divide.
module dscl_interp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  dscl_pkg::seg_t                in_seg,
    output logic                          out_valid,
    output logic [dscl_pkg::TempW-1:0]    out_temp
);
    localparam int PW = dscl_pkg::ProdW;
    localparam int SW = dscl_pkg::SpanW;
    localparam int QW = dscl_pkg::DropW;
    localparam int Steps = 4;
    localparam int Bps = (QW + Steps - 1) / Steps;
    localparam int QTot = Bps * Steps;

    // Multiply stage.
    logic                        mv_reg;
    logic                        mclamp_reg;
    logic [dscl_pkg::TempW-1:0]  mtlo_reg;
    logic [PW-1:0]               prod_reg;
    logic [SW-1:0]               mspan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 1'b0;
        else if (adv)
            mv_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mclamp_reg <= in_seg.clamp;
            mtlo_reg   <= in_seg.t_lo;
            prod_reg   <= in_seg.drop * in_seg.off;
            mspan_reg  <= in_seg.span;
        end
    end

    // Divide stages; quotient fits in DropW bits since off <= span.
    // The product bits above the quotient range are already below the divisor,
    // so they seed the partial remainder.
    logic                        dv_reg   [Steps];
    logic                        dcl_reg  [Steps];
    logic [dscl_pkg::TempW-1:0]  dtlo_reg [Steps];
    logic [SW-1:0]               dspan_reg[Steps];
    logic [PW-1:0]               dnum_reg [Steps];
    logic [SW:0]                 drem_reg [Steps];
    logic [QTot-1:0]             dq_reg   [Steps];
    logic [PW-1:0]               dnum_next[Steps];
    logic [SW:0]                 drem_next[Steps];
    logic [QTot-1:0]             dq_next  [Steps];

    always_comb
    begin
        logic [PW-1:0]   n;
        logic [SW:0]     r;
        logic [QTot-1:0] q;
        logic [SW-1:0]   d;
        logic [SW+1:0]   t;
        for (int k = 0; k < Steps; k++)
        begin
            if (k == 0)
            begin
                n = prod_reg << (PW - QTot);
                r = (SW+1)'(prod_reg[PW-1:QTot]);
                q = '0;
                d = mspan_reg;
            end
            else
            begin
                n = dnum_reg[k-1];
                r = drem_reg[k-1];
                q = dq_reg[k-1];
                d = dspan_reg[k-1];
            end
            for (int b = 0; b < Bps; b++)
            begin
                t = {r, n[PW-1]};
                n = n << 1;
                if (t >= {2'b00, d})
                begin
                    t = t - {2'b00, d};
                    q = {q[QTot-2:0], 1'b1};
                end
                else
                    q = {q[QTot-2:0], 1'b0};
                r = t[SW:0];
            end
            dnum_next[k] = n;
            drem_next[k] = r;
            dq_next[k]   = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < Steps; k++)
                dv_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            dv_reg[0] <= mv_reg;
            for (int k = 1; k < Steps; k++)
                dv_reg[k] <= dv_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dcl_reg[0]   <= mclamp_reg;
            dtlo_reg[0]  <= mtlo_reg;
            dspan_reg[0] <= mspan_reg;
            for (int k = 0; k < Steps; k++)
            begin
                dnum_reg[k] <= dnum_next[k];
                drem_reg[k] <= drem_next[k];
                dq_reg[k]   <= dq_next[k];
            end
            for (int k = 1; k < Steps; k++)
            begin
                dcl_reg[k]   <= dcl_reg[k-1];
                dtlo_reg[k]  <= dtlo_reg[k-1];
                dspan_reg[k] <= dspan_reg[k-1];
            end
        end
    end

    // Final subtract stage.
    logic                        ov_reg;
    logic [dscl_pkg::TempW-1:0]  ot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= dv_reg[Steps-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (dcl_reg[Steps-1])
                ot_reg <= dtlo_reg[Steps-1];
            else
                ot_reg <= dtlo_reg[Steps-1]
                          - dscl_pkg::TempW'(dq_reg[Steps-1][QW-1:0]);
        end
    end

    assign out_valid = ov_reg;
    assign out_temp  = ot_reg;

endmodule
